/* rtl/wfra_pkg.sv */
// wfra_pkg: shared types and codes for the worst-fit region allocator.
// Used by wfra_ctrl, wfra_dp and the top level.
`default_nettype none
package wfra_pkg;
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;
  localparam logic [1:0] OP_STATUS  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_GAP   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;

  localparam int MAX_RESULTS = 16;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request fields, reset scan pointers
    logic step;      // advance the scan by one slot
    logic commit;    // apply request insertion
    logic emit;      // load output register from current slot
    logic emit_fix;  // load output register with fixed status
    logic [2:0] fix_status;
    logic fix_total; // fixed result carries compact total as size
    logic fix_req;   // fixed result carries placed region
  } wfra_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // scan pointer has passed the used slots
    logic match;      // current slot matches the release id
    logic full;
    logic empty;
    logic fits;
    logic any_freed;
    logic cap;        // result count reached the limit
    logic more;       // a later slot will still be reported for this request
  } wfra_stat_t;
endpackage
`default_nettype wire

/* rtl/worst_fit_region_allocator_top.sv */
// Channel  | signals                                   | dir
// input    | in_valid in_ready opcode region_id request_size | in
// result   | out_valid out_ready status out_id out_start out_size last | out
// config   | cfg_valid cfg_ready cfg_data (memory_size)  | in
// One request at a time; the scan visits one used slot per cycle unless it stalls (an allocation
// also scans the gap after the last slot); zero size, full table, empty listing skip the scan.
// One output register; the scan stalls only when a result is due while it holds one not yet taken.
// cfg_ready is high only while idle; rst is synchronous, table empty, memory_size all ones.
// Depends on wfra_pkg, wfra_ctrl, wfra_dp.
`default_nettype none
module worst_fit_region_allocator_top #(
  parameter int SLOTS = 16,
  parameter int ADDR_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] region_id,
  input  wire logic [15:0] request_size,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [2:0] status,
  output logic [7:0] out_id,
  output logic [15:0] out_start,
  output logic [15:0] out_size,
  output logic last,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [15:0] cfg_data
);
  wfra_pkg::wfra_cmd_t cmd;
  wfra_pkg::wfra_stat_t stat;
  logic last_next;
  logic busy;
  logic out_take;

  assign cfg_ready = in_ready;
  assign busy = out_valid && !out_ready;
  assign out_take = out_valid && out_ready;

  wfra_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .opcode, .request_size,
    .out_busy(busy), .last_next, .stat, .cmd
  );

  wfra_dp #(.SLOTS(SLOTS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .op_in(opcode), .id_in(region_id),
    .size_in(request_size), .cfg_we(cfg_valid && cfg_ready), .cfg_data,
    .out_take, .out_last_in(last_next),
    .out_valid, .o_status(status), .o_id(out_id),
    .o_start(out_start), .o_size(out_size), .o_last(last)
  );

`ifndef SYNTH
  a_noacc_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({status, out_id, out_start, out_size, last})))
    else $error("result changed while waiting");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("idle with result pending");
`endif
endmodule
`default_nettype wire

/* rtl/wfra_dp.sv */
// wfra_dp: slot table, gap scan, shift/compact datapath and output register.
// Depends on wfra_pkg; driven by wfra_ctrl.
`default_nettype none
module wfra_dp #(
  parameter int SLOTS = 16,
  parameter int ADDR_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire wfra_pkg::wfra_cmd_t cmd,
  output wfra_pkg::wfra_stat_t stat,
  input  wire logic [1:0] op_in,
  input  wire logic [7:0] id_in,
  input  wire logic [15:0] size_in,
  input  wire logic cfg_we,
  input  wire logic [15:0] cfg_data,
  input  wire logic out_take,
  input  wire logic out_last_in,
  output logic out_valid,
  output logic [2:0] o_status,
  output logic [7:0] o_id,
  output logic [15:0] o_start,
  output logic [15:0] o_size,
  output logic o_last
);
  localparam int IW = $clog2(SLOTS + 1);
  localparam int PW = $clog2(SLOTS);
  localparam int TW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam int CW = TW + 1;
  localparam logic [ADDR_BITS-1:0] AMASK = '1;

  logic [ADDR_BITS-1:0] mem_size;
  logic [SLOTS-1:0] valid;
  logic [7:0] owner [SLOTS];
  logic [ADDR_BITS-1:0] base [SLOTS];
  logic [ADDR_BITS-1:0] len [SLOTS];

  logic [1:0] op;
  logic [7:0] id;
  logic [15:0] rsize;
  logic [IW-1:0] ptr, wr, n;
  logic [ADDR_BITS:0] prev_end, best, best_start;
  logic [TW-1:0] total;
  logic [IW-1:0] pos;
  logic [4:0] kcnt;
  logic later;

  logic [PW-1:0] pi, wi;
  logic [ADDR_BITS:0] end_v, gap, cur_end;
  assign pi = ptr[PW-1:0];
  assign wi = wr[PW-1:0];

  always_comb begin
    n = '0;
    for (int i = 0; i < SLOTS; i++) if (valid[i]) n = IW'(i + 1);
  end

  always_comb begin
    if (ptr < n) end_v = {1'b0, base[pi]};
    else end_v = {1'b0, mem_size};
    gap = (end_v > prev_end) ? end_v - prev_end : '0;
    cur_end = {1'b0, base[pi]} + {1'b0, len[pi]};
  end

  // another matching slot further up the table
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (IW'(i) > ptr && IW'(i) < n && owner[i] == id) later = 1'b1;
  end

  assign stat.scan_done = (op == wfra_pkg::OP_REQUEST) ? (ptr > n) : (ptr >= n);
  assign stat.match = owner[pi] == id;
  assign stat.full = n == IW'(SLOTS);
  assign stat.empty = n == '0;
  assign stat.fits = CW'(best) >= CW'(rsize);
  assign stat.any_freed = wr != ptr;
  assign stat.cap = kcnt == 5'(wfra_pkg::MAX_RESULTS);
  assign stat.more = (kcnt != 5'(wfra_pkg::MAX_RESULTS - 1)) &&
                     ((op == wfra_pkg::OP_STATUS) ? (ptr + 1'b1 < n) : later);

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= AMASK & ADDR_BITS'(16'hFFFF);
      valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) mem_size <= ADDR_BITS'(cfg_data);
      if (cmd.emit || cmd.emit_fix) out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
      if (cmd.load) begin
        op <= op_in; id <= id_in; rsize <= size_in;
        ptr <= '0; wr <= '0; prev_end <= '0; best <= '0; best_start <= '0;
        pos <= '0; total <= '0; kcnt <= '0;
      end
      if (cmd.step) begin
        ptr <= ptr + 1'b1;
        unique case (op)
          wfra_pkg::OP_REQUEST: begin
            if (gap > best) begin
              best <= gap; best_start <= prev_end; pos <= ptr;
            end
            if (ptr < n) prev_end <= cur_end;
          end
          wfra_pkg::OP_RELEASE: begin
            if (!stat.match) begin
              owner[wi] <= owner[pi]; base[wi] <= base[pi]; len[wi] <= len[pi];
              wr <= wr + 1'b1;
            end
            if (ptr + 1'b1 >= n) begin
              for (int i = 0; i < SLOTS; i++)
                if (IW'(i) >= wr + IW'(!stat.match)) valid[i] <= 1'b0;
            end
          end
          wfra_pkg::OP_COMPACT: begin
            base[pi] <= total[ADDR_BITS-1:0];
            total <= total + TW'(len[pi]);
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        for (int i = 1; i < SLOTS; i++)
          if (IW'(i) > pos && IW'(i) <= n) begin
            valid[i] <= valid[i-1]; owner[i] <= owner[i-1];
            base[i] <= base[i-1]; len[i] <= len[i-1];
          end
        valid[pos[PW-1:0]] <= 1'b1;
        owner[pos[PW-1:0]] <= id;
        base[pos[PW-1:0]] <= best_start[ADDR_BITS-1:0];
        len[pos[PW-1:0]] <= ADDR_BITS'(rsize);
      end
      if (cmd.emit) begin
        kcnt <= kcnt + 1'b1;
        o_status <= wfra_pkg::ST_OK; o_id <= owner[pi];
        o_start <= 16'(base[pi]); o_size <= 16'(len[pi]);
        o_last <= out_last_in;
      end
      if (cmd.emit_fix) begin
        o_status <= cmd.fix_status; o_id <= cmd.fix_req ? id : 8'd0;
        o_start <= cmd.fix_req ? 16'(best_start) : 16'd0;
        o_size <= cmd.fix_req ? rsize : (cmd.fix_total ? 16'(total) : 16'd0);
        o_last <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/wfra_ctrl.sv */
// wfra_ctrl: sequencing state machine of the allocator.
// Depends on wfra_pkg; commands wfra_dp.
`default_nettype none
module wfra_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [15:0] request_size,
  input  wire logic out_busy,
  output logic last_next,
  input  wire wfra_pkg::wfra_stat_t stat,
  output wfra_pkg::wfra_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_DECIDE, S_WAIT} state_t;
  state_t state;
  logic [1:0] op;
  logic zero;
  logic emitted;
  logic check_fix;

  assign in_ready = state == S_IDLE;

  // requests answered right after the check, without a scan
  assign check_fix = (op == wfra_pkg::OP_REQUEST && (zero || stat.full)) ||
                     (op == wfra_pkg::OP_STATUS && stat.empty);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      emitted <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= opcode; zero <= request_size == 16'd0; emitted <= 1'b0;
          state <= S_CHECK;
        end
        S_CHECK: state <= check_fix ? S_WAIT : S_SCAN;
        S_SCAN: begin
          if (op == wfra_pkg::OP_RELEASE && !stat.scan_done && stat.match
              && !stat.cap) begin
            if (!out_busy) emitted <= 1'b1;
          end
          if (stat.scan_done) state <= S_DECIDE;
        end
        S_DECIDE: if (!out_busy) state <= S_WAIT;
        S_WAIT: if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Listing/release: <=1 region per step; only emits wait on full output.
  logic want_emit;
  always_comb begin
    cmd = '0;
    last_next = 1'b0;
    want_emit = 1'b0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_CHECK: begin
        if (op == wfra_pkg::OP_REQUEST && (zero || stat.full)) begin
          cmd.emit_fix = 1'b1;
          cmd.fix_status = zero ? wfra_pkg::ST_ZERO : wfra_pkg::ST_FULL;
        end else if (op == wfra_pkg::OP_STATUS && stat.empty) begin
          cmd.emit_fix = 1'b1; cmd.fix_status = wfra_pkg::ST_EMPTY;
        end
      end
      S_SCAN: if (!stat.scan_done) begin
        unique case (op)
          wfra_pkg::OP_STATUS: want_emit = !stat.cap;
          wfra_pkg::OP_RELEASE: want_emit = stat.match && !stat.cap;
          default: want_emit = 1'b0;
        endcase
        if (!(want_emit && out_busy)) begin
          cmd.step = 1'b1;
          cmd.emit = want_emit;
          last_next = !stat.more;
        end
      end
      S_DECIDE: unique case (op)
        wfra_pkg::OP_REQUEST: if (!out_busy) begin
          cmd.emit_fix = 1'b1;
          if (stat.fits) begin
            cmd.commit = 1'b1; cmd.fix_req = 1'b1; cmd.fix_status = wfra_pkg::ST_OK;
          end else cmd.fix_status = wfra_pkg::ST_NO_GAP;
        end
        wfra_pkg::OP_COMPACT: if (!out_busy) begin
          cmd.emit_fix = 1'b1; cmd.fix_total = 1'b1; cmd.fix_status = wfra_pkg::ST_OK;
        end
        wfra_pkg::OP_RELEASE: if (!out_busy && !emitted) begin
          cmd.emit_fix = 1'b1; cmd.fix_status = wfra_pkg::ST_NOT_FND;
        end
        default: ;
      endcase
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* test/tb_top.sv */
// tb_top: self-checking bench for worst_fit_region_allocator_top.
// Drives region requests and config writes, predicts results with a local table model.
// Depends on wfra_pkg and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  id;
    logic [15:0] size;
    logic        is_cfg;
    logic [15:0] cfg_val;
  } req_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [7:0]  id;
    logic [15:0] start;
    logic [15:0] size;
    logic        last;
  } res_t;

  localparam int NSLOT = 16;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = '0;
  logic [7:0] region_id = '0;
  logic [15:0] request_size = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] out_id;
  logic [15:0] out_start;
  logic [15:0] out_size;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  worst_fit_region_allocator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .region_id(region_id), .request_size(request_size),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_id(out_id), .out_start(out_start),
    .out_size(out_size), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [15:0] mem_units = 16'hFFFF;
  int          n_used = 0;
  logic [7:0]  own [NSLOT];
  logic [16:0] base [NSLOT];
  logic [16:0] len [NSLOT];

  req_t pending [$];
  res_t expected_results [$];
  int   mismatches = 0;
  int   cycles = 0;
  int   hold_off = 0;
  bit   stim_done = 0;

  function automatic void push_res(logic [2:0] st, logic [7:0] id, logic [16:0] s,
                                   logic [31:0] z);
    res_t r;
    r.st = st; r.id = id; r.start = s[15:0]; r.size = z[15:0]; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_alloc(req_t t);
    int pos, w, k;
    logic [16:0] prev_end, best, best_start, e, gap;
    logic [31:0] total;
    case (t.op)
      wfra_pkg::OP_REQUEST: begin
        if (t.size == '0) push_res(wfra_pkg::ST_ZERO, '0, '0, '0);
        else if (n_used >= NSLOT) push_res(wfra_pkg::ST_FULL, '0, '0, '0);
        else begin
          prev_end = '0; best = '0; best_start = '0; pos = 0;
          for (int i = 0; i <= n_used; i++) begin
            e = (i < n_used) ? base[i] : {1'b0, mem_units};
            gap = (e > prev_end) ? e - prev_end : '0;
            if (gap > best) begin
              best = gap; best_start = prev_end; pos = i;
            end
            if (i < n_used) prev_end = base[i] + len[i];
          end
          if (best < {1'b0, t.size}) push_res(wfra_pkg::ST_NO_GAP, '0, '0, '0);
          else begin
            for (int i = n_used; i > pos; i--) begin
              own[i] = own[i-1]; base[i] = base[i-1]; len[i] = len[i-1];
            end
            own[pos] = t.id; base[pos] = best_start; len[pos] = {1'b0, t.size};
            n_used++;
            push_res(wfra_pkg::ST_OK, t.id, best_start, {16'd0, t.size});
          end
        end
      end
      wfra_pkg::OP_RELEASE: begin
        w = 0; k = 0;
        for (int i = 0; i < n_used; i++) begin
          if (own[i] == t.id) begin
            if (k < wfra_pkg::MAX_RESULTS)
              push_res(wfra_pkg::ST_OK, t.id, base[i], {15'd0, len[i]});
            k++;
          end else begin
            own[w] = own[i]; base[w] = base[i]; len[w] = len[i]; w++;
          end
        end
        n_used = w;
        if (k == 0) push_res(wfra_pkg::ST_NOT_FND, '0, '0, '0);
      end
      wfra_pkg::OP_COMPACT: begin
        total = '0;
        for (int i = 0; i < n_used; i++) begin
          base[i] = {1'b0, total[15:0]};
          total += {15'd0, len[i]};
        end
        push_res(wfra_pkg::ST_OK, '0, '0, total);
      end
      default: begin
        if (n_used == 0) push_res(wfra_pkg::ST_EMPTY, '0, '0, '0);
        else for (int i = 0; i < n_used && i < wfra_pkg::MAX_RESULTS; i++)
          push_res(wfra_pkg::ST_OK, own[i], base[i], {15'd0, len[i]});
      end
    endcase
    expected_results[expected_results.size()-1].last = 1'b1;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    req_t t;
    cycles <= cycles + 1;
    if (!rst) begin
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        t = pending.pop_front();
        if (t.is_cfg) mem_units = t.cfg_val;
        else predict_alloc(t);
        in_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (in_gap > 0 && !(in_valid || cfg_valid)) in_gap--;
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || !(in_valid || cfg_valid)) begin
        if (pending.size() > 0 && in_gap == 0 &&
            !(pending[0].is_cfg && expected_results.size() > 0)) begin
          t = pending[0];
          in_valid <= !t.is_cfg;
          cfg_valid <= t.is_cfg;
          opcode <= t.op; region_id <= t.id; request_size <= t.size;
          cfg_data <= t.cfg_val;
        end else begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    res_t r, a;
    if (!rst) begin
      if (out_valid && out_ready) begin
        a.st = status; a.id = out_id; a.start = out_start; a.size = out_size; a.last = last;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", a);
        end else begin
          r = expected_results.pop_front();
          if (r !== a) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p actual %p", r, a);
          end
        end
        out_gap = $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0) out_gap = 0;
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  function automatic req_t mk(logic [1:0] op, logic [7:0] id, logic [15:0] sz);
    req_t t;
    t = '0; t.op = op; t.id = id; t.size = sz;
    return t;
  endfunction

  function automatic req_t mk_cfg(logic [15:0] v);
    req_t t;
    t = '0; t.is_cfg = 1'b1; t.cfg_val = v;
    return t;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed: empty cases, zero size, extremes, full table, release many
    pending.push_back(mk(wfra_pkg::OP_STATUS, 8'd0, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'hFF, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_COMPACT, 8'd0, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'd1, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'hFF, 16'hFFFF));
    pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'd2, 16'hFFFF));
    pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'hFF, 16'd0));
    pending.push_back(mk_cfg(16'd40));
    for (int i = 0; i < 17; i++)
      pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'(i % 3), 16'd2));
    pending.push_back(mk(wfra_pkg::OP_STATUS, 8'd0, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'd1, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'd7, 16'd30));
    pending.push_back(mk(wfra_pkg::OP_COMPACT, 8'd0, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_STATUS, 8'd0, 16'd0));
    // shrink below existing regions
    pending.push_back(mk_cfg(16'd1));
    pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'd9, 16'd1));
    pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'd0, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'd2, 16'd0));
    pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'd9, 16'd1));
    // long receiver stall while requests keep coming
    wait (pending.size() == 0 && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    hold_off = 300;
    for (int i = 0; i < 12; i++) pending.push_back(mk(wfra_pkg::OP_STATUS, 8'd0, 16'd0));
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending.size() == 0 && expected_results.size() == 0);
      repeat (20) @(posedge clk);
      case (ph)
        0: pending.push_back(mk_cfg(16'hFFFF));
        1: pending.push_back(mk_cfg(16'(ph * 100 + 60)));
        2: pending.push_back(mk_cfg(16'($urandom)));
        default: pending.push_back(mk_cfg(16'd300));
      endcase
      for (int i = 0; i < 18; i++) begin
        int sel;
        logic [15:0] sz;
        sel = $urandom_range(0, 9);
        sz = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
        if (sel < 5)
          pending.push_back(mk(wfra_pkg::OP_REQUEST, 8'($urandom_range(0, 5)), sz));
        else if (sel < 7)
          pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'($urandom_range(0, 6)), 16'd0));
        else if (sel < 8)
          pending.push_back(mk(wfra_pkg::OP_RELEASE, 8'($urandom), 16'($urandom)));
        else if (sel < 9)
          pending.push_back(mk(wfra_pkg::OP_COMPACT, 8'($urandom), 16'($urandom)));
        else pending.push_back(mk(wfra_pkg::OP_STATUS, 8'($urandom), 16'($urandom)));
      end
    end
    wait (pending.size() == 0 && expected_results.size() == 0);
    stim_done = 1;
  end

  initial begin
    wait (stim_done || cycles >= LIMIT);
    if (!stim_done) begin
      $display("Mismatches found");
      $finish;
    end else begin
      repeat (50) @(posedge clk);
      if (mismatches == 0 && expected_results.size() == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* files.f */
rtl/wfra_pkg.sv
rtl/wfra_dp.sv
rtl/wfra_ctrl.sv
rtl/worst_fit_region_allocator_top.sv
test/tb_top.sv
